// ----- sv/msf_pkg.sv -----
// Shared types and constants for the minimum-energy seam finder.
// Depends on nothing; msf_unit, the top level and the testbench files import it.
`default_nettype none

package msf_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int SIZE_W     = 7;
   localparam int IDX_W      = $clog2(MAX_WIDTH);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int PIXEL_W    = 24;
   localparam int COST_W     = 25;
   localparam int STEP_W     = 3;

   localparam logic [1:0] REG_WIDTH     = 2'd0;
   localparam logic [1:0] REG_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_DIRECTION = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ENERGY,
      ST_DP,
      ST_SEARCH,
      ST_OUT,
      ST_TRACE
   } state_type;

   typedef enum logic {
      UOP_PAIR,
      UOP_COST
   } unit_op_type;

   typedef struct packed {
      unit_op_type               op;
      logic [COST_W-1:0]         acc;
      logic [COST_W-1:0]         addend;
      logic [PIXEL_W-1:0]        px_a;
      logic [PIXEL_W-1:0]        px_b;
      logic [COST_W-1:0]         cmp_a;
      logic [COST_W-1:0]         cmp_b;
   } unit_in_type;

   typedef struct packed {
      logic [COST_W-1:0] sum;
      logic              lt;
      logic              eq;
   } unit_out_type;

endpackage

`default_nettype wire

// ----- sv/msf_req_if.sv -----
// Request channel carrying one RGB pixel.
// Depends on nothing.
`default_nettype none

interface msf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- sv/msf_rsp_if.sv -----
// Response channel carrying one seam index.
// Depends on nothing.
`default_nettype none

interface msf_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] seam_index;
   logic       seam_last;

   modport source(output valid, output seam_index, output seam_last, input ready);
   modport sink(input valid, input seam_index, input seam_last, output ready);
endinterface

`default_nettype wire

// ----- sv/msf_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module msf_ram #(
   parameter int WIDTH  = 24,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] store_ff [1 << ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wdata;
      end
      rdata_ff <= store_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/msf_unit.sv -----
// Shared arithmetic unit: pixel-pair energy, saturating cost add and compare.
// Depends on msf_pkg.
`default_nettype none

module msf_unit
   import msf_pkg::*;
(
   input  wire unit_in_type  unit_in,
   output unit_out_type      unit_out
);

   logic [7:0]        d_r, d_g, d_b;
   logic [17:0]       pair;
   logic [COST_W-1:0] addend;
   logic [COST_W:0]   total;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   always_comb begin
      d_r    = abs_diff(unit_in.px_a[23:16], unit_in.px_b[23:16]);
      d_g    = abs_diff(unit_in.px_a[15:8], unit_in.px_b[15:8]);
      d_b    = abs_diff(unit_in.px_a[7:0], unit_in.px_b[7:0]);
      pair   = 18'(d_r * d_r) + 18'(d_g * d_g) + 18'(d_b * d_b);
      addend = (unit_in.op == UOP_PAIR) ? COST_W'(pair) : unit_in.addend;
      total  = {1'b0, unit_in.acc} + {1'b0, addend};
      unit_out.sum = total[COST_W] ? {COST_W{1'b1}} : total[COST_W-1:0];
      unit_out.lt  = unit_in.cmp_a < unit_in.cmp_b;
      unit_out.eq  = unit_in.cmp_a == unit_in.cmp_b;
   end

endmodule

`default_nettype wire

// ----- sv/min_energy_seam_finder.sv -----
// Top level of the seam finder: sequencer, pixel and cost stores, shared unit.
// Depends on msf_pkg, msf_req_if, msf_rsp_if, msf_ram and msf_unit.
//
//   channel  direction  payload                 handshake
//   req_bus  in         red, green, blue        valid/ready
//   rsp_bus  out        seam_index, seam_last   valid/ready
//   csr_*    in         index, write data       write enable only
//
// Pixels are taken one a cycle while the block is in its load state. After the
// last pixel come the energy pass over every pixel, the cost pass over every
// pixel of all but the far line, the start search over the near line and the
// seam steps, each one handing an index over; the single ports of the stores
// set the pace. The request side is not ready until the last index has been
// taken. Reset clears control state only; the stores are not cleared.
`default_nettype none

module min_energy_seam_finder
   import msf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   msf_req_if.sink                req_bus,
   msf_rsp_if.source              rsp_bus,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [SIZE_W-1:0] csr_wdata
);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SIZE_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic               dir_ff, dir_in;
   logic [IDX_W-1:0]   maj_ff, maj_in, mn_ff, mn_in, pos_ff, pos_in;
   logic [COST_W-1:0]  acc_ff, acc_in, s_ff, s_in, lo_ff, lo_in;
   logic [PIXEL_W-1:0] px_ff, px_in;

   logic               p_we, c_we;
   logic [ADDR_W-1:0]  p_addr, c_addr;
   logic [PIXEL_W-1:0] p_rdata;
   logic [COST_W-1:0]  c_wdata, c_rdata;
   unit_in_type        u_in;
   unit_out_type       u_out;

   logic [IDX_W-1:0]   w_m1, h_m1, nmaj_m1, nmn_m1;
   logic [IDX_W-1:0]   lc, rc, ur, dr;
   logic               req_acc, rsp_acc, last_pixel, mn_last, maj_last;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      if (v < SIZE_W'(2)) begin
         return SIZE_W'(2);
      end
      if (v > maxv) begin
         return maxv;
      end
      return v;
   endfunction

   function automatic logic [ADDR_W-1:0] cost_addr(input logic [IDX_W-1:0] maj,
                                                  input logic [IDX_W-1:0] mn,
                                                  input logic dir);
      return dir ? {mn, maj} : {maj, mn};
   endfunction

   msf_ram #(.WIDTH(PIXEL_W), .ADDR_W(ADDR_W)) u_pixel_ram (
      .clock(clock), .we(p_we), .addr(p_addr),
      .wdata({req_bus.red, req_bus.green, req_bus.blue}), .rdata(p_rdata)
   );

   msf_ram #(.WIDTH(COST_W), .ADDR_W(ADDR_W)) u_cost_ram (
      .clock(clock), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
   );

   msf_unit u_unit (.unit_in(u_in), .unit_out(u_out));

   assign w_m1       = IDX_W'(width_ff - SIZE_W'(1));
   assign h_m1       = IDX_W'(height_ff - SIZE_W'(1));
   assign nmaj_m1    = dir_ff ? w_m1 : h_m1;
   assign nmn_m1     = dir_ff ? h_m1 : w_m1;
   assign lc         = (mn_ff == '0) ? w_m1 : mn_ff - IDX_W'(1);
   assign rc         = (mn_ff == w_m1) ? '0 : mn_ff + IDX_W'(1);
   assign ur         = (maj_ff == '0) ? h_m1 : maj_ff - IDX_W'(1);
   assign dr         = (maj_ff == h_m1) ? '0 : maj_ff + IDX_W'(1);
   assign req_acc    = req_bus.valid && req_bus.ready;
   assign rsp_acc    = rsp_bus.valid && rsp_bus.ready;
   assign last_pixel = (maj_ff == h_m1) && (mn_ff == w_m1);
   assign mn_last    = mn_ff == nmn_m1;
   assign maj_last   = maj_ff == nmaj_m1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc && last_pixel) state_in = ST_ENERGY;
         end
         ST_ENERGY: begin
            if (step_ff == STEP_W'(4) && last_pixel) state_in = ST_DP;
         end
         ST_DP: begin
            if (step_ff == STEP_W'(4) && mn_last && maj_ff == '0) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (step_ff == STEP_W'(1) && mn_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_acc) state_in = maj_last ? ST_LOAD : ST_TRACE;
         end
         ST_TRACE: begin
            if (step_ff == STEP_W'(4)) state_in = ST_OUT;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_bus.ready      = state_ff == ST_LOAD;
      rsp_bus.valid      = state_ff == ST_OUT;
      rsp_bus.seam_index = pos_ff;
      rsp_bus.seam_last  = maj_last;
   end

   always_comb begin
      step_in   = step_ff + STEP_W'(1);
      width_in  = width_ff;
      height_in = height_ff;
      dir_in    = dir_ff;
      maj_in    = maj_ff;
      mn_in     = mn_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      s_in      = s_ff;
      lo_in     = lo_ff;
      px_in     = px_ff;
      p_we      = 1'b0;
      p_addr    = {maj_ff, mn_ff};
      c_we      = 1'b0;
      c_addr    = cost_addr(maj_ff, mn_ff, dir_ff);
      c_wdata   = u_out.sum;
      u_in      = '{op: UOP_PAIR, acc: '0, addend: acc_ff, px_a: px_ff, px_b: p_rdata,
                    cmp_a: c_rdata, cmp_b: acc_ff};

      case (state_ff)
         ST_LOAD: begin
            step_in = '0;
            if (req_acc) begin
               p_we = 1'b1;
               if (mn_ff == w_m1) begin
                  mn_in  = '0;
                  maj_in = (maj_ff == h_m1) ? '0 : maj_ff + IDX_W'(1);
               end else begin
                  mn_in = mn_ff + IDX_W'(1);
               end
            end
         end
         ST_ENERGY: begin
            case (step_ff)
               STEP_W'(0): p_addr = {maj_ff, lc};
               STEP_W'(1): begin
                  p_addr = {maj_ff, rc};
                  px_in  = p_rdata;
               end
               STEP_W'(2): begin
                  p_addr = {ur, mn_ff};
                  acc_in = u_out.sum;
               end
               STEP_W'(3): begin
                  p_addr = {dr, mn_ff};
                  px_in  = p_rdata;
               end
               default: begin
                  u_in.acc = acc_ff;
                  c_we     = 1'b1;
                  c_addr   = {maj_ff, mn_ff};
                  step_in  = '0;
                  if (last_pixel) begin
                     maj_in = nmaj_m1 - IDX_W'(1);
                     mn_in  = '0;
                  end else if (mn_ff == w_m1) begin
                     mn_in  = '0;
                     maj_in = maj_ff + IDX_W'(1);
                  end else begin
                     mn_in = mn_ff + IDX_W'(1);
                  end
               end
            endcase
         end
         ST_DP: begin
            case (step_ff)
               STEP_W'(0): c_addr = cost_addr(maj_ff + IDX_W'(1), mn_ff, dir_ff);
               STEP_W'(1): begin
                  c_addr = cost_addr(maj_ff + IDX_W'(1), mn_ff - IDX_W'(1), dir_ff);
                  acc_in = c_rdata;
               end
               STEP_W'(2): begin
                  c_addr = cost_addr(maj_ff + IDX_W'(1), mn_ff + IDX_W'(1), dir_ff);
                  if (mn_ff != '0 && u_out.lt) acc_in = c_rdata;
               end
               STEP_W'(3): begin
                  if (!mn_last && u_out.lt) acc_in = c_rdata;
               end
               default: begin
                  u_in.op  = UOP_COST;
                  u_in.acc = c_rdata;
                  c_we     = 1'b1;
                  step_in  = '0;
                  if (mn_last) begin
                     mn_in  = '0;
                     maj_in = (maj_ff == '0) ? '0 : maj_ff - IDX_W'(1);
                  end else begin
                     mn_in = mn_ff + IDX_W'(1);
                  end
               end
            endcase
         end
         ST_SEARCH: begin
            if (step_ff != '0) begin
               step_in = '0;
               if (mn_ff == '0 || u_out.lt) begin
                  acc_in = c_rdata;
                  pos_in = mn_ff;
               end
               mn_in = mn_last ? '0 : mn_ff + IDX_W'(1);
            end
         end
         ST_OUT: begin
            step_in = '0;
            if (rsp_acc) begin
               maj_in = maj_last ? '0 : maj_ff + IDX_W'(1);
               mn_in  = '0;
            end
         end
         ST_TRACE: begin
            case (step_ff)
               STEP_W'(0): c_addr = cost_addr(maj_ff, pos_ff, dir_ff);
               STEP_W'(1): begin
                  c_addr = cost_addr(maj_ff, pos_ff - IDX_W'(1), dir_ff);
                  s_in   = c_rdata;
                  acc_in = c_rdata;
               end
               STEP_W'(2): begin
                  c_addr = cost_addr(maj_ff, pos_ff + IDX_W'(1), dir_ff);
                  lo_in  = c_rdata;
                  if (pos_ff != '0 && u_out.lt) acc_in = c_rdata;
               end
               STEP_W'(3): begin
                  if (pos_ff != nmn_m1 && u_out.lt) acc_in = c_rdata;
               end
               default: begin
                  u_in.cmp_a = s_ff;
                  step_in    = '0;
                  if (u_out.eq) begin
                     pos_in = pos_ff;
                  end else if (pos_ff != '0 && lo_ff == acc_ff) begin
                     pos_in = pos_ff - IDX_W'(1);
                  end else begin
                     pos_in = pos_ff + IDX_W'(1);
                  end
               end
            endcase
         end
         default: step_in = '0;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH: begin
               width_in = clamp_size(csr_wdata, SIZE_W'(MAX_WIDTH));
               maj_in   = '0;
               mn_in    = '0;
            end
            REG_HEIGHT: begin
               height_in = clamp_size(csr_wdata, SIZE_W'(MAX_HEIGHT));
               maj_in    = '0;
               mn_in     = '0;
            end
            REG_DIRECTION: dir_in = csr_wdata[0];
            default: dir_in = dir_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         step_ff   <= '0;
         width_ff  <= SIZE_W'(MAX_WIDTH);
         height_ff <= SIZE_W'(MAX_HEIGHT);
         dir_ff    <= 1'b0;
         maj_ff    <= '0;
         mn_ff     <= '0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         dir_ff    <= dir_in;
         maj_ff    <= maj_in;
         mn_ff     <= mn_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      s_ff   <= s_in;
      lo_ff  <= lo_in;
      px_ff  <= px_in;
   end

endmodule

`default_nettype wire

// ----- tb/msf_seam_model.sv -----
// Behavioural seam finder used by the test to work out the expected seam indexes.
// Depends on msf_pkg for the size limits and field widths.
`default_nettype none

package msf_seam_model;
   import msf_pkg::*;

   localparam int COST_SAT = (1 << COST_W) - 1;

   typedef struct packed {
      logic [5:0] seam_index;
      logic       seam_last;
   } seam_step_type;

   // Configuration and loading state held by the predictor.
   int unsigned cols = MAX_WIDTH;
   int unsigned rows = MAX_HEIGHT;
   bit          horizontal = 1'b0;
   int unsigned loaded = 0;
   logic [PIXEL_W-1:0] pixels [MAX_WIDTH*MAX_HEIGHT];
   int unsigned        costs  [MAX_WIDTH*MAX_HEIGHT];

   function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
      if (v < 2) return 2;
      if (v > top) return top;
      return v;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [SIZE_W-1:0] data);
      if (idx == REG_WIDTH) begin
         cols = clamp_size(data, MAX_WIDTH);
         loaded = 0;
      end else if (idx == REG_HEIGHT) begin
         rows = clamp_size(data, MAX_HEIGHT);
         loaded = 0;
      end else if (idx == REG_DIRECTION) begin
         horizontal = data[0];
      end
   endfunction

   function automatic int unsigned gradient(logic [PIXEL_W-1:0] p, logic [PIXEL_W-1:0] q);
      int unsigned total;
      int d;
      total = 0;
      for (int ch = 0; ch < 3; ch++) begin
         d = int'(p[ch*8 +: 8]) - int'(q[ch*8 +: 8]);
         total += d * d;
      end
      return total;
   endfunction

   function automatic int unsigned add_sat(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > COST_SAT) ? COST_SAT : int'(s);
   endfunction

   // Cost at position p of line k; k is the running coordinate of the seam.
   function automatic int unsigned cost_at(int unsigned k, int unsigned p);
      return horizontal ? costs[p*cols + k] : costs[k*cols + p];
   endfunction

   // Best of straight, lower and higher neighbours; straight wins ties.
   function automatic int unsigned best_pos(int unsigned k, int unsigned p,
                                            int unsigned span);
      int unsigned m, pick;
      pick = p;
      m = cost_at(k, p);
      if (p > 0 && cost_at(k, p - 1) < m) begin
         m = cost_at(k, p - 1);
         pick = p - 1;
      end
      if (p + 1 < span && cost_at(k, p + 1) < m) pick = p + 1;
      return pick;
   endfunction

   // Takes one pixel; returns the seam in out when the image is complete.
   function automatic void take_pixel(logic [PIXEL_W-1:0] px, ref seam_step_type out[$]);
      int unsigned total, lc, rc, ur, dr, lines, span, pos, nb;
      total = cols * rows;
      out.delete();
      if (loaded >= total) loaded = 0;
      pixels[loaded] = px;
      loaded++;
      if (loaded < total) return;
      loaded = 0;
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++) begin
            lc = (c == 0) ? cols - 1 : c - 1;
            rc = (c + 1 == cols) ? 0 : c + 1;
            ur = (r == 0) ? rows - 1 : r - 1;
            dr = (r + 1 == rows) ? 0 : r + 1;
            costs[r*cols + c] = gradient(pixels[r*cols + lc], pixels[r*cols + rc])
                              + gradient(pixels[ur*cols + c], pixels[dr*cols + c]);
         end
      lines = horizontal ? cols : rows;
      span  = horizontal ? rows : cols;
      for (int k = lines - 2; k >= 0; k--)
         for (int p = 0; p < span; p++) begin
            nb = cost_at(k + 1, best_pos(k + 1, p, span));
            if (horizontal) costs[p*cols + k] = add_sat(costs[p*cols + k], nb);
            else costs[k*cols + p] = add_sat(costs[k*cols + p], nb);
         end
      pos = 0;
      for (int p = 1; p < span; p++)
         if (cost_at(0, p) < cost_at(0, pos)) pos = p;
      for (int k = 0; k < lines; k++) begin
         if (k > 0) pos = best_pos(k, pos, span);
         out.push_back('{seam_index: pos[5:0], seam_last: (k + 1 == lines)});
      end
   endfunction

endpackage

`default_nettype wire

// ----- tb/min_energy_seam_finder_test.sv -----
// Test of the seam finder: drives pixel requests, compares every seam index with a
// behavioural model. Depends on msf_pkg, msf_req_if, msf_rsp_if, msf_seam_model and min_energy_seam_finder.
`default_nettype none

module min_energy_seam_finder_test;
   import msf_pkg::*;
   import msf_seam_model::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [SIZE_W-1:0] csr_wdata = '0;
   int send_idle = 0;
   int take_idle = 0;
   int mismatches = 0;
   seam_step_type expected_seam[$];

   msf_req_if req_bus();
   msf_rsp_if rsp_bus();

   min_energy_seam_finder dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      rsp_bus.ready = 1'b0;
   end

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_seam.size() == 0) begin
            report("unexpected index", int'(rsp_bus.seam_index), -1);
         end else begin
            if (rsp_bus.seam_index !== expected_seam[0].seam_index)
               report("seam_index", int'(rsp_bus.seam_index),
                      int'(expected_seam[0].seam_index));
            if (rsp_bus.seam_last !== expected_seam[0].seam_last)
               report("seam_last", int'(rsp_bus.seam_last),
                      int'(expected_seam[0].seam_last));
            void'(expected_seam.pop_front());
         end
      end
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= take_idle);
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      seam_step_type seam[$];
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red <= r;
      req_bus.green <= g;
      req_bus.blue <= b;
      do @(posedge clock); while (!req_bus.ready);
      take_pixel({r, g, b}, seam);
      foreach (seam[i]) expected_seam.push_back(seam[i]);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_seam.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [SIZE_W-1:0] data);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(idx, data);
   endtask

   task automatic send_image(int mode);
      logic [7:0] v;
      for (int i = 0; i < cols * rows; i++) begin
         v = (mode == 0) ? 8'd0 : (mode == 1) ? 8'd255 : 8'($urandom_range(255));
         send_pixel(v, (mode == 2) ? 8'($urandom_range(255)) : v,
                    (mode == 2) ? 8'($urandom_range(255)) : v);
      end
   endtask

   // Extremes of size, flat images, saturating values and the unknown index.
   task automatic test_directed();
      write_csr(REG_WIDTH, 7'd0);
      write_csr(REG_HEIGHT, 7'd1);
      write_csr(REG_DIRECTION, 7'd0);
      write_csr(REG_UNUSED, 7'd5);
      send_image(0);
      send_image(1);
      write_csr(REG_DIRECTION, 7'd1);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      write_csr(REG_WIDTH, 7'd3);
      send_pixel(8'd10, 8'd20, 8'd30);
      write_csr(REG_HEIGHT, 7'd3);
      send_image(2);
   endtask

   // Random images at small sizes in both directions.
   task automatic test_random(int images);
      for (int n = 0; n < images; n++) begin
         write_csr(REG_WIDTH, SIZE_W'($urandom_range(2, 5)));
         write_csr(REG_HEIGHT, SIZE_W'($urandom_range(2, 5)));
         write_csr(REG_DIRECTION, SIZE_W'($urandom_range(1)));
         send_image(2);
      end
   endtask

   task automatic test_large();
      write_csr(REG_WIDTH, 7'd127);
      write_csr(REG_HEIGHT, 7'd2);
      send_image(2);
      write_csr(REG_DIRECTION, 7'd0);
      write_csr(REG_WIDTH, 7'd2);
      write_csr(REG_HEIGHT, 7'd64);
      send_image(2);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 19;
      take_idle = 56;
      test_directed();
      test_random(2);
      send_idle = 56;
      take_idle = 19;
      test_random(2);
      send_idle = 0;
      take_idle = 0;
      test_random(1);
      test_large();
      drain();
      if (mismatches == 0 && expected_seam.size() == 0)
         $display("min_energy_seam_finder_test: PASS");
      else
         $display("min_energy_seam_finder_test: FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("min_energy_seam_finder_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
